/* rtl/prtm_pkg.sv */
package prtm_pkg;

    // Field and register widths fixed by the item format
    localparam int PRIME_W    = 5;
    localparam int IDX_W      = 5;
    localparam int COEF_W     = 18;
    localparam int RES_W      = 32;

    // Reset value of the prime register
    localparam logic [PRIME_W-1:0] PRIME_RESET = 5'd3;

    // sqrt(2) in Q1.15, accumulator clamp and output scaling
    localparam int SQRT2_Q15  = 46341;
    localparam int CLAMP_LOG  = 47;
    localparam int CLAMP_W    = CLAMP_LOG + 2;
    localparam int SPLIT_LO   = 24;
    localparam int SPLIT_HI_W = CLAMP_W - SPLIT_LO;
    localparam int OUT_SHIFT  = 31;

    // Item kinds
    localparam logic KIND_TABLE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_CLAMP,
        ST_SLO,
        ST_SHI,
        ST_FIN,
        ST_EMIT
    } t_state;

    // Steps of the shared multiply/accumulate unit
    typedef struct packed {
        logic term;
        logic clear;
        logic clamp;
        logic scale_lo;
        logic scale_hi;
        logic finish;
        logic load_pass;
    } t_mac_ctl;

    // Read request to the coefficient and sample memories
    typedef struct packed {
        logic               sel_imag;
        logic [PRIME_W-1:0] coef_idx;
        logic [PRIME_W-1:0] samp_idx;
    } t_rd_req;

endpackage

/* rtl/prtm_if.sv */
interface prtm_in_if #(
    parameter int SAMPLE_BITS = 24
);
    import prtm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [IDX_W-1:0]         table_index;
    logic signed [COEF_W-1:0] coef_real;
    logic signed [COEF_W-1:0] coef_imag;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (
        output valid, kind, table_index, coef_real, coef_imag, sample,
        input  ready
    );
    modport sink (
        input  valid, kind, table_index, coef_real, coef_imag, sample,
        output ready
    );
endinterface

interface prtm_cfg_if;
    import prtm_pkg::*;

    logic               valid;
    logic               ready;
    logic [PRIME_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

interface prtm_out_if;
    import prtm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] result_value;
    logic                    result_last;

    modport source (output valid, result_value, result_last, input ready);
    modport sink (input valid, result_value, result_last, output ready);
endinterface

/* rtl/prime_root_table_matvec_top.sv */
// Prime-size transform over a loadable table of inverse roots of unity. Kind 0
// items write one table entry; kind 1 items collect the p-1 samples of a vector,
// and the last sample starts the transform, which emits p-1 results in row order
// with result_last on the final one (for p = 2 the sample passes through). After
// the last sample the block is busy and takes no items: each row runs p-1
// multiply-accumulates through one shared multiplier of 18 bits by the larger of
// the sample width and 25 bits, drains the read and multiply stages, clamps,
// scales by sqrt(2) on the same multiplier in two halves, rounds and saturates,
// and hands the result to the output register once that register is free. Write
// the prime only while the block is idle; a write discards any partly collected
// vector but keeps the table.
module prime_root_table_matvec_top #(
    parameter int MAX_PRIME   = 31,
    parameter int SAMPLE_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    prtm_in_if.sink     i_in,
    prtm_cfg_if.sink    i_cfg,
    prtm_out_if.source  o_out
);
    import prtm_pkg::*;

    logic                     ready;
    logic                     tbl_we;
    logic                     vec_we;
    logic [PRIME_W-1:0]       vec_idx;
    t_rd_req                  rd_req;
    t_mac_ctl                 mac_ctl;
    logic signed [COEF_W-1:0] rd_coef;
    logic signed [SAMPLE_BITS-1:0] rd_samp;
    logic signed [RES_W-1:0]  mac_res;
    logic                     out_free;
    logic                     emit;
    logic                     last;

    logic                     r_out_valid;
    logic signed [RES_W-1:0]  r_out_value;
    logic                     r_out_last;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = ready;
    assign tbl_we      = i_in.valid && ready && (i_in.kind == KIND_TABLE);
    assign out_free    = !r_out_valid || o_out.ready;

    prtm_seq #(
        .MAX_PRIME (MAX_PRIME)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_prime  (i_cfg.data),
        .i_item_valid (i_in.valid),
        .i_kind       (i_in.kind),
        .o_ready      (ready),
        .o_vec_we     (vec_we),
        .o_vec_idx    (vec_idx),
        .o_rd         (rd_req),
        .o_ctl        (mac_ctl),
        .i_out_free   (out_free),
        .o_emit       (emit),
        .o_last       (last)
    );

    prtm_store #(
        .MAX_PRIME   (MAX_PRIME),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_store (
        .i_clk       (i_clk),
        .i_tbl_we    (tbl_we),
        .i_tbl_idx   (i_in.table_index),
        .i_coef_real (i_in.coef_real),
        .i_coef_imag (i_in.coef_imag),
        .i_vec_we    (vec_we),
        .i_vec_idx   (vec_idx),
        .i_sample    (i_in.sample),
        .i_rd        (rd_req),
        .o_coef      (rd_coef),
        .o_samp      (rd_samp)
    );

    prtm_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_coef  (rd_coef),
        .i_samp  (rd_samp),
        .i_pass  (i_in.sample),
        .o_res   (mac_res)
    );

    // Hold a result until its transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_value <= mac_res;
            r_out_last  <= last;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_out_value;
    assign o_out.result_last  = r_out_last;

endmodule

/* rtl/prtm_store.sv */
module prtm_store #(
    parameter int MAX_PRIME   = 31,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_tbl_we,
    input  logic [prtm_pkg::IDX_W-1:0]       i_tbl_idx,
    input  logic signed [prtm_pkg::COEF_W-1:0] i_coef_real,
    input  logic signed [prtm_pkg::COEF_W-1:0] i_coef_imag,
    input  logic                             i_vec_we,
    input  logic [prtm_pkg::PRIME_W-1:0]     i_vec_idx,
    input  logic signed [SAMPLE_BITS-1:0]    i_sample,
    input  prtm_pkg::t_rd_req                i_rd,
    output logic signed [prtm_pkg::COEF_W-1:0] o_coef,
    output logic signed [SAMPLE_BITS-1:0]    o_samp
);
    import prtm_pkg::*;

    localparam int DEPTH = MAX_PRIME + 1;
    localparam int AW    = $clog2(DEPTH);

    logic signed [COEF_W-1:0]      r_real_mem [DEPTH];
    logic signed [COEF_W-1:0]      r_imag_mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_vec_mem  [DEPTH];
    logic signed [COEF_W-1:0]      r_coef;
    logic signed [SAMPLE_BITS-1:0] r_samp;

    // Write a table entry; drop indexes beyond the table
    always_ff @(posedge i_clk) begin
        if (i_tbl_we && (int'(i_tbl_idx) <= MAX_PRIME)) begin
            r_real_mem[AW'(i_tbl_idx)] <= i_coef_real;
            r_imag_mem[AW'(i_tbl_idx)] <= i_coef_imag;
        end
    end

    // Write one vector sample
    always_ff @(posedge i_clk) begin
        if (i_vec_we) begin
            r_vec_mem[AW'(i_vec_idx)] <= i_sample;
        end
    end

    // Registered reads, real or imaginary half picked by column
    always_ff @(posedge i_clk) begin
        r_coef <= i_rd.sel_imag ? r_imag_mem[AW'(i_rd.coef_idx)]
                                : r_real_mem[AW'(i_rd.coef_idx)];
        r_samp <= r_vec_mem[AW'(i_rd.samp_idx)];
    end

    assign o_coef = r_coef;
    assign o_samp = r_samp;

endmodule

/* rtl/prtm_mac.sv */
module prtm_mac #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  prtm_pkg::t_mac_ctl                 i_ctl,
    input  logic signed [prtm_pkg::COEF_W-1:0] i_coef,
    input  logic signed [SAMPLE_BITS-1:0]      i_samp,
    input  logic signed [SAMPLE_BITS-1:0]      i_pass,
    output logic signed [prtm_pkg::RES_W-1:0]  o_res
);
    import prtm_pkg::*;

    localparam int MA_W  = (SAMPLE_BITS > SPLIT_HI_W) ? SAMPLE_BITS : SPLIT_HI_W;
    localparam int P_W   = MA_W + COEF_W;
    localparam int ACC_W = SAMPLE_BITS + COEF_W + 5;
    localparam int CW    = (ACC_W > CLAMP_W) ? ACC_W : CLAMP_W;
    localparam int PLO_W = SPLIT_LO + COEF_W;
    localparam int SUM_W = 66;
    localparam int SH_W  = SUM_W - OUT_SHIFT;

    localparam logic signed [CW-1:0] CLAMP_HI = CW'(64'sd1 <<< CLAMP_LOG);
    localparam logic signed [CW-1:0] CLAMP_LO = -CLAMP_HI;

    logic                     r_v1;
    logic                     r_v2;
    logic signed [P_W-1:0]    r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [CLAMP_W-1:0] r_clamp;
    logic [PLO_W-1:0]         r_plo;
    logic signed [RES_W-1:0]  r_res;

    logic signed [MA_W-1:0]   mul_a;
    logic signed [COEF_W-1:0] mul_b;
    logic signed [P_W-1:0]    mul_p;
    logic signed [CW-1:0]     acc_ext;
    logic signed [CLAMP_W-1:0] clamp_n;
    logic signed [SUM_W-1:0]  sum;
    logic [SH_W-1:0]          shifted;
    logic [SH_W-RES_W:0]      upper;
    logic signed [RES_W-1:0]  sat;

    // Pick multiplier operands: sample times coefficient, or a half of the
    // clamped sum times sqrt(2)
    always_comb begin
        mul_a = MA_W'(i_samp);
        mul_b = i_coef;
        if (i_ctl.scale_lo) begin
            mul_a = MA_W'($signed({1'b0, r_clamp[SPLIT_LO-1:0]}));
            mul_b = COEF_W'(SQRT2_Q15);
        end else if (i_ctl.scale_hi) begin
            mul_a = MA_W'($signed(r_clamp[CLAMP_W-1:SPLIT_LO]));
            mul_b = COEF_W'(SQRT2_Q15);
        end
        mul_p = mul_a * mul_b;
    end

    // Clamp the row sum to plus or minus 2^47
    always_comb begin
        acc_ext = CW'(r_acc);
        if (acc_ext > CLAMP_HI) begin
            clamp_n = CLAMP_W'(CLAMP_HI);
        end else if (acc_ext < CLAMP_LO) begin
            clamp_n = CLAMP_W'(CLAMP_LO);
        end else begin
            clamp_n = CLAMP_W'(acc_ext);
        end
    end

    // Join the partial products, round half up, saturate to 32 bits
    always_comb begin
        sum     = (SUM_W'(r_prod) <<< SPLIT_LO) + SUM_W'($signed({1'b0, r_plo}));
        shifted = sum[SUM_W-1:OUT_SHIFT];
        upper   = shifted[SH_W-1:RES_W-1];
        if ((upper == '0) || (upper == '1)) begin
            sat = shifted[RES_W-1:0];
        end else if (shifted[SH_W-1]) begin
            sat = {1'b1, {(RES_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(RES_W-1){1'b1}}};
        end
    end

    // Track term validity through read and multiply stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.term;
            r_v2 <= r_v1;
        end
    end

    // Shared multiplier, accumulator and scaling registers
    always_ff @(posedge i_clk) begin
        if (r_v1 || i_ctl.scale_lo || i_ctl.scale_hi) begin
            r_prod <= mul_p;
        end
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_ctl.clamp) begin
            r_clamp <= clamp_n;
        end
        if (i_ctl.scale_hi) begin
            r_plo <= r_prod[PLO_W-1:0] + (PLO_W'(1) << (OUT_SHIFT - 1));
        end
        if (i_ctl.finish) begin
            r_res <= sat;
        end else if (i_ctl.load_pass) begin
            r_res <= RES_W'(i_pass);
        end
    end

    assign o_res = r_res;

endmodule

/* rtl/prtm_seq.sv */
module prtm_seq #(
    parameter int MAX_PRIME = 31
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [prtm_pkg::PRIME_W-1:0] i_cfg_prime,
    input  logic                         i_item_valid,
    input  logic                         i_kind,
    output logic                         o_ready,
    output logic                         o_vec_we,
    output logic [prtm_pkg::PRIME_W-1:0] o_vec_idx,
    output prtm_pkg::t_rd_req            o_rd,
    output prtm_pkg::t_mac_ctl           o_ctl,
    input  logic                         i_out_free,
    output logic                         o_emit,
    output logic                         o_last
);
    import prtm_pkg::*;

    t_state             r_state, n_state;
    logic [PRIME_W-1:0] r_prime, n_prime;
    logic [PRIME_W-1:0] r_count, n_count;
    logic [PRIME_W-1:0] r_row, n_row;
    logic [PRIME_W-1:0] r_c, n_c;
    logic [PRIME_W-1:0] r_k, n_k;
    logic               r_dly, n_dly;

    logic [PRIME_W-1:0] p_eff;
    logic [PRIME_W-1:0] n_len;
    logic [PRIME_W-1:0] half;
    logic [PRIME_W-1:0] cnt_idx;
    logic [PRIME_W:0]   k_sum;
    logic [PRIME_W:0]   k_red;
    logic [PRIME_W-1:0] k_next;

    // Effective prime, vector length and column split
    always_comb begin
        if (r_prime < PRIME_W'(2)) begin
            p_eff = PRIME_W'(2);
        end else if (int'(r_prime) > MAX_PRIME) begin
            p_eff = PRIME_W'(MAX_PRIME);
        end else begin
            p_eff = r_prime;
        end
        n_len   = p_eff - PRIME_W'(1);
        half    = p_eff >> 1;
        cnt_idx = (r_count >= n_len) ? '0 : r_count;
        k_sum   = {1'b0, r_k} + {1'b0, r_row};
        k_red   = k_sum - {1'b0, p_eff};
        k_next  = (k_sum >= {1'b0, p_eff}) ? k_red[PRIME_W-1:0] : k_sum[PRIME_W-1:0];
    end

    // State and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_prime <= PRIME_RESET;
            r_count <= '0;
            r_row   <= '0;
            r_c     <= '0;
            r_k     <= '0;
            r_dly   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_prime <= n_prime;
            r_count <= n_count;
            r_row   <= n_row;
            r_c     <= n_c;
            r_k     <= n_k;
            r_dly   <= n_dly;
        end
    end

    // Next state and step controls
    always_comb begin
        n_state  = r_state;
        n_prime  = r_prime;
        n_count  = r_count;
        n_row    = r_row;
        n_c      = r_c;
        n_k      = r_k;
        n_dly    = r_dly;
        o_ctl    = '0;
        o_ready  = 1'b0;
        o_vec_we = 1'b0;
        o_emit   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_item_valid && (i_kind == KIND_SAMPLE)) begin
                    o_vec_we = 1'b1;
                    if (cnt_idx == (n_len - PRIME_W'(1))) begin
                        n_count = '0;
                        n_row   = '0;
                        if (p_eff == PRIME_W'(2)) begin
                            o_ctl.load_pass = 1'b1;
                            n_state         = ST_EMIT;
                        end else begin
                            o_ctl.clear = 1'b1;
                            n_c         = PRIME_W'(1);
                            n_k         = '0;
                            n_state     = ST_MAC;
                        end
                    end else begin
                        n_count = cnt_idx + PRIME_W'(1);
                    end
                end
            end
            ST_MAC: begin
                o_ctl.term = 1'b1;
                n_c        = r_c + PRIME_W'(1);
                n_k        = k_next;
                if (r_c == n_len) begin
                    n_dly   = 1'b0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_dly = 1'b1;
                if (r_dly) begin
                    n_state = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                o_ctl.clamp = 1'b1;
                n_state     = ST_SLO;
            end
            ST_SLO: begin
                o_ctl.scale_lo = 1'b1;
                n_state        = ST_SHI;
            end
            ST_SHI: begin
                o_ctl.scale_hi = 1'b1;
                n_state        = ST_FIN;
            end
            ST_FIN: begin
                o_ctl.finish = 1'b1;
                n_state      = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_out_free) begin
                    o_emit = 1'b1;
                    if (r_row == (n_len - PRIME_W'(1))) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_ctl.clear = 1'b1;
                        n_row       = r_row + PRIME_W'(1);
                        n_k         = r_row + PRIME_W'(1);
                        n_c         = PRIME_W'(1);
                        n_state     = ST_MAC;
                    end
                end
            end
        endcase

        // Take a new prime and drop any partial vector
        if (i_cfg_we) begin
            n_prime = i_cfg_prime;
            n_count = '0;
        end
    end

    assign o_vec_idx     = cnt_idx;
    assign o_rd.sel_imag = (r_c > half);
    assign o_rd.coef_idx = r_k;
    assign o_rd.samp_idx = r_c - PRIME_W'(1);
    assign o_last        = (r_row == (n_len - PRIME_W'(1)));

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> (r_k < p_eff))
        else $error("table index out of range during accumulation");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> ((r_c >= PRIME_W'(1)) && (r_c <= n_len)))
        else $error("column counter out of range");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_count < n_len))
        else $error("sample count beyond vector length");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && o_last) |=> (r_state == ST_IDLE))
        else $error("sequencer did not return to idle after last result");

endmodule
